[hw/rtl/lws_pkg.sv]
// Shared constants and reset table for the lottery winner select block.
`timescale 1ns / 1ps

package lws_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_JOBS    = 4;
    localparam int DEF_TICKET_BITS = 10;

    // Fixed field widths
    localparam int DRAW_W     = 31;
    localparam int RUNS_W     = 32;
    localparam int IDX_W      = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int DRAW_CNT_W = $clog2(DRAW_W);

    // Configuration register file
    localparam int NUM_TICKET_REGS = 4;
    localparam int CFG_IDX_W       = 2;

    localparam logic [RUNS_W-1:0] RUN_MAX = {RUNS_W{1'b1}};

    // Ticket count after reset, before masking to the ticket width
    function automatic logic [15:0] ticket_reset(input int j);
        logic [15:0] v;
        case (j)
            0:       v = 16'd50;
            1:       v = 16'd100;
            2:       v = 16'd250;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/lottery_winner_select.sv]
// Lottery winner select: proportional-share arbiter with a bit-serial modulo unit.
`timescale 1ns / 1ps
//
// Usage
//   Slave stream (i_s_*): one beat per time slice, tdata[30:0] = random draw.
//   Master stream (o_m_*): one result beat per input beat, in order.
//     tdata[1:0] = winner index, tdata[33:2] = winner run count, rest zero.
//     tuser[0]   = no tickets (ticket total is zero; nothing chosen or counted).
//   Config channel (i_cfg_*): write ticket count of job i at index i; write only
//     while the block is idle. Indexes at or above NUM_JOBS are dropped.
// Timing
//   Per beat: add up the ticket total one job at a time, run the bit-serial
//   modulo (one draw bit per cycle through a shift register), walk the jobs,
//   bump the run counter and load the output register. A zero ticket total
//   skips the modulo, the walk and the counter bump.
//   One beat is in flight at a time.
// Reset
//   Synchronous, active low: ticket counts return to 50/100/250/0, run counters
//   clear, both streams go empty.
// Stall
//   A finished result waits in the output register; the next draw is still
//   accepted and worked on, and it holds in its last state until the slot frees.

module lottery_winner_select
    import lws_pkg::*;
#(
    parameter int NUM_JOBS    = DEF_NUM_JOBS,
    parameter int TICKET_BITS = DEF_TICKET_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream: [30:0] random_draw, [31] zero
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    // master stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [1:0] winner_index, [33:2] winner_runs, [39:34] zero
    output logic [M_TDATA_W-1:0]   o_m_tdata,
    // [0] no_tickets
    output logic                   o_m_tuser,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [TICKET_BITS-1:0] i_cfg_data
);

    localparam int JOB_W = $clog2(NUM_JOBS);
    localparam int SUM_W = TICKET_BITS + JOB_W;
    localparam logic [JOB_W-1:0] LAST_JOB = JOB_W'(NUM_JOBS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_WALK,
        ST_UPD,
        ST_DONE
    } t_state;

    t_state                  r_state;
    logic [TICKET_BITS-1:0]  r_tickets [NUM_JOBS];
    logic [RUNS_W-1:0]       r_runs    [NUM_JOBS];
    logic [DRAW_W-1:0]       r_draw;
    logic [DRAW_CNT_W-1:0]   r_cnt;
    logic [JOB_W-1:0]        r_job;
    logic [SUM_W-1:0]        r_total;
    logic [SUM_W-1:0]        r_rem;
    logic [SUM_W-1:0]        r_sum;
    logic [JOB_W-1:0]        r_win;
    logic [RUNS_W-1:0]       r_res_runs;
    logic [IDX_W-1:0]        r_res_idx;
    logic                    r_res_none;
    logic                    r_out_valid;
    logic [RUNS_W-1:0]       r_out_runs;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_none;

    logic [TICKET_BITS-1:0]  w_tick;
    logic [SUM_W:0]          w_shift;
    logic [SUM_W-1:0]        n_rem;
    logic [SUM_W-1:0]        n_total;
    logic [SUM_W-1:0]        n_sum;
    logic [RUNS_W-1:0]       w_cur_runs;
    logic [RUNS_W-1:0]       n_runs;
    logic                    w_out_free;

    assign w_tick = r_tickets[r_job];

    // One restoring step: shift in the next draw bit, subtract the total if it fits
    always_comb begin
        w_shift = {r_rem, r_draw[DRAW_W-1]};
        if (w_shift >= {1'b0, r_total}) begin
            n_rem = SUM_W'(w_shift - {1'b0, r_total});
        end else begin
            n_rem = w_shift[SUM_W-1:0];
        end
    end

    assign n_total    = r_total + SUM_W'(w_tick);
    assign n_sum      = r_sum + SUM_W'(w_tick);
    assign w_cur_runs = r_runs[r_win];
    assign n_runs     = (w_cur_runs == RUN_MAX) ? w_cur_runs : w_cur_runs + 1'b1;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(M_TDATA_W - RUNS_W - IDX_W){1'b0}}, r_out_runs, r_out_idx};
    assign o_m_tuser   = r_out_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int j = 0; j < NUM_JOBS; j++) begin
                r_tickets[j] <= TICKET_BITS'(ticket_reset(j));
                r_runs[j]    <= '0;
            end
        end else begin
            // ticket writes, dropped for jobs that do not exist
            if (i_cfg_valid) begin
                for (int j = 0; j < NUM_JOBS; j++) begin
                    if (j < NUM_TICKET_REGS && i_cfg_index == CFG_IDX_W'(j)) begin
                        r_tickets[j] <= i_cfg_data;
                    end
                end
            end

            // drop the taken beat unless a new one loads in the same cycle
            if (r_out_valid && i_m_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_draw  <= i_s_tdata[DRAW_W-1:0];
                        r_job   <= '0;
                        r_total <= '0;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_total <= n_total;
                    if (r_job == LAST_JOB) begin
                        r_job <= '0;
                        r_rem <= '0;
                        r_cnt <= '0;
                        if (n_total == '0) begin
                            r_res_runs <= '0;
                            r_res_idx  <= '0;
                            r_res_none <= 1'b1;
                            r_state    <= ST_DONE;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end else begin
                        r_job <= r_job + 1'b1;
                    end
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_draw <= {r_draw[DRAW_W-2:0], 1'b0};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == DRAW_CNT_W'(DRAW_W - 1)) begin
                        r_sum   <= '0;
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    r_sum <= n_sum;
                    // first job whose running sum passes the pick wins
                    if (n_sum > r_rem || r_job == LAST_JOB) begin
                        r_win   <= r_job;
                        r_state <= ST_UPD;
                    end else begin
                        r_job <= r_job + 1'b1;
                    end
                end
                ST_UPD: begin
                    r_runs[r_win] <= n_runs;
                    r_res_runs    <= n_runs;
                    r_res_idx     <= IDX_W'(r_win);
                    r_res_none    <= 1'b0;
                    r_state       <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_runs  <= r_res_runs;
                        r_out_idx   <= r_res_idx;
                        r_out_none  <= r_res_none;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the lottery winner select block.
`timescale 1ns / 1ps

module tb_top;
    import lws_pkg::*;

    localparam int NUM_JOBS     = DEF_NUM_JOBS;
    localparam int TICKET_BITS  = DEF_TICKET_BITS;
    // Random draws after the directed part
    localparam int RANDOM_DRAWS = 1600;
    // Receiver hold-off, long enough to fill the block and stall its input
    localparam int HOLD_CYCLES  = 400;
    // A beat and its idle gaps on each side are short next to the hold-off;
    // the hold-off dominates, so allow several times that.
    localparam int STALL_LIMIT  = 2000;
    // Drain time after the last result
    localparam int TAIL_CYCLES  = 60;

    typedef logic [NUM_JOBS-1:0][TICKET_BITS-1:0] share_set_t;

    // Expected content of one result beat
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [RUNS_W-1:0] runs;
        logic              no_tickets;
    } slice_result_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    // [30:0] random_draw, [31] zero
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    // [1:0] winner_index, [33:2] winner_runs, [39:34] zero
    logic [M_TDATA_W-1:0]   o_m_tdata;
    // [0] no_tickets
    logic                   o_m_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [TICKET_BITS-1:0] i_cfg_data  = '0;

    // Local copy of the block's ticket table and run counters
    logic [TICKET_BITS-1:0] ticket_share [NUM_JOBS];
    logic [RUNS_W-1:0]      run_tally    [NUM_JOBS];

    logic [DRAW_W-1:0]      draw_q[$];
    slice_result_t          winners_q[$];

    int items_pushed       = 0;
    int draws_offered      = 0;
    int draws_taken        = 0;
    int results_seen       = 0;
    int no_ticket_results  = 0;
    int settings_run       = 1;
    int fail_cnt           = 0;
    int unsigned tx_wait   = 0;
    int unsigned rx_wait   = 0;
    int unsigned quiet_cycles = 0;

    lottery_winner_select #(
        .NUM_JOBS    (NUM_JOBS),
        .TICKET_BITS (TICKET_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Reduce the draw modulo the ticket total, walk the jobs in order and
    // bump the winner's counter, holding it at the top.
    function automatic slice_result_t pick_winner(input logic [DRAW_W-1:0] draw);
        slice_result_t r;
        logic [31:0]   total;
        logic [31:0]   pick;
        logic [31:0]   acc;
        int            win;
        r     = '0;
        total = '0;
        acc   = '0;
        win   = -1;
        for (int j = 0; j < NUM_JOBS; j++)
            total += 32'(ticket_share[j]);
        if (total == 0) begin
            // Nothing to choose from: flag it and leave every counter alone.
            r.no_tickets = 1'b1;
            return r;
        end
        pick = {1'b0, draw} % total;
        for (int j = 0; j < NUM_JOBS; j++) begin
            acc += 32'(ticket_share[j]);
            if (win < 0 && acc > pick)
                win = j;
        end
        if (run_tally[win] != RUN_MAX)
            run_tally[win] = run_tally[win] + 1'b1;
        r.idx  = IDX_W'(win);
        r.runs = run_tally[win];
        return r;
    endfunction

    // Idle cycles per beat; every fourth stretch of 64 beats runs without gaps.
    function automatic int unsigned idle_cycles(input int n);
        return (((n / 64) % 4) == 3) ? 0 : $urandom_range(0, 10);
    endfunction

    // Mix full-width draws with small ones and draws near the top.
    function automatic logic [DRAW_W-1:0] random_draw();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 3))
            1:       return DRAW_W'($urandom_range(0, 8191));
            2:       return {DRAW_W{1'b1}} - DRAW_W'($urandom_range(0, 255));
            default: return raw[DRAW_W-1:0];
        endcase
    endfunction

    // Ticket table with zeros, ones and full-scale shares mixed in.
    function automatic share_set_t random_shares();
        share_set_t s;
        s = '0;
        if ($urandom_range(0, 7) == 0)
            return s;
        for (int j = 0; j < NUM_JOBS; j++) begin
            case ($urandom_range(0, 5))
                0:       s[j] = '0;
                1:       s[j] = {TICKET_BITS{1'b1}};
                2:       s[j] = TICKET_BITS'(1);
                default: s[j] = TICKET_BITS'($urandom_range(0, (1 << TICKET_BITS) - 1));
            endcase
        end
        return s;
    endfunction

    task automatic queue_draw(input logic [DRAW_W-1:0] d);
        draw_q.push_back(d);
        items_pushed++;
    endtask

    // Block until every queued draw has come back as a result.
    task automatic wait_drained();
        while (results_seen != items_pushed)
            @(posedge i_clk);
    endtask

    // Write all ticket registers back to back; keep valid high across beats.
    task automatic program_tickets(input share_set_t shares);
        for (int j = 0; j < NUM_JOBS; j++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(j);
            i_cfg_data  <= shares[j];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            ticket_share[j] = shares[j];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Draw driver: offer the next queued draw, hold it until taken, then idle
    // for the gap drawn when it was offered. Predict at the accepting edge.
    always @(posedge i_clk) begin : draw_driver
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_wait    <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                winners_q.push_back(pick_winner(i_s_tdata[DRAW_W-1:0]));
                draws_taken++;
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold the beat until the block takes it
            end else if (tx_wait != 0) begin
                i_s_tvalid <= 1'b0;
                tx_wait    <= tx_wait - 1;
            end else if (draw_q.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {{(S_TDATA_W - DRAW_W){1'b0}}, draw_q.pop_front()};
                tx_wait    <= idle_cycles(draws_offered);
                draws_offered++;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: check each beat against the oldest prediction, then
    // drop ready for a random gap, or for a long hold-off twice per run.
    always @(posedge i_clk) begin : result_monitor
        slice_result_t want;
        int unsigned   w;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_wait    <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (o_m_tuser)
                no_ticket_results++;
            if (winners_q.size() == 0) begin
                $error("result beat with nothing expected: tdata=%h tuser=%b",
                       o_m_tdata, o_m_tuser);
                fail_cnt++;
            end else begin
                want = winners_q.pop_front();
                if (o_m_tdata[IDX_W-1:0] !== want.idx) begin
                    $error("winner_index: expected %0d, got %0d",
                           want.idx, o_m_tdata[IDX_W-1:0]);
                    fail_cnt++;
                end
                if (o_m_tdata[IDX_W +: RUNS_W] !== want.runs) begin
                    $error("winner_runs: expected %0d, got %0d",
                           want.runs, o_m_tdata[IDX_W +: RUNS_W]);
                    fail_cnt++;
                end
                if (o_m_tuser !== want.no_tickets) begin
                    $error("no_tickets: expected %0b, got %0b", want.no_tickets, o_m_tuser);
                    fail_cnt++;
                end
            end
            w = (results_seen == 40 || results_seen == 900) ? HOLD_CYCLES
                                                              : idle_cycles(results_seen);
            rx_wait    <= w;
            i_m_tready <= (w == 0);
        end else if (rx_wait != 0) begin
            rx_wait    <= rx_wait - 1;
            i_m_tready <= (rx_wait == 1);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long.
    always @(posedge i_clk) begin : watchdog
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d of %0d results in",
                     STALL_LIMIT, results_seen, items_pushed);
            $display("FAIL lottery_winner_select");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int n;
        ticket_share = '{TICKET_BITS'(50), TICKET_BITS'(100), TICKET_BITS'(250), '0};
        for (int j = 0; j < NUM_JOBS; j++)
            run_tally[j] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset shares 50/100/250/0: bucket edges, the top draw, bit patterns.
        queue_draw(DRAW_W'(0));
        queue_draw(DRAW_W'(49));
        queue_draw(DRAW_W'(50));
        queue_draw(DRAW_W'(149));
        queue_draw(DRAW_W'(150));
        queue_draw(DRAW_W'(399));
        queue_draw(DRAW_W'(400));
        queue_draw(DRAW_W'(799));
        queue_draw({DRAW_W{1'b1}});
        queue_draw(DRAW_W'(31'h5555_5555));
        queue_draw(DRAW_W'(31'h2AAA_AAAA));
        wait_drained();

        // Full-scale shares everywhere.
        program_tickets({NUM_JOBS{{TICKET_BITS{1'b1}}}});
        settings_run++;
        queue_draw(DRAW_W'(0));
        queue_draw(DRAW_W'(1022));
        queue_draw(DRAW_W'(1023));
        queue_draw(DRAW_W'(4091));
        queue_draw(DRAW_W'(4092));
        queue_draw({DRAW_W{1'b1}});
        wait_drained();

        // Zero ticket total: flag set, counters untouched.
        program_tickets('0);
        settings_run++;
        queue_draw(DRAW_W'(0));
        queue_draw({DRAW_W{1'b1}});
        queue_draw(DRAW_W'(12345));
        wait_drained();

        // Only the last job holds a ticket, so it must win every draw.
        program_tickets({TICKET_BITS'(1), {(NUM_JOBS - 1){{TICKET_BITS{1'b0}}}}});
        settings_run++;
        queue_draw(DRAW_W'(0));
        queue_draw({DRAW_W{1'b1}});
        wait_drained();

        // Random phases: new ticket table, a batch of draws, drain, repeat.
        n = items_pushed + RANDOM_DRAWS;
        while (items_pushed < n) begin
            program_tickets(random_shares());
            settings_run++;
            repeat ($urandom_range(60, 140))
                queue_draw(random_draw());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (winners_q.size() != 0) begin
            $error("%0d expected results never arrived", winners_q.size());
            fail_cnt++;
        end
        $display("covered %0d draws over %0d ticket tables, %0d with no tickets",
                 draws_taken, settings_run, no_ticket_results);
        $display("receiver held off twice for %0d cycles; %0d failures", HOLD_CYCLES, fail_cnt);
        if (fail_cnt == 0) begin
            $display("PASS lottery_winner_select");
        end else begin
            $display("FAIL lottery_winner_select");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/lws_pkg.sv
hw/rtl/lottery_winner_select.sv
sim/tb_top.sv
